### hdl/crt_pkg.sv
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types, codes and constants of the cascadable reload timer.
// ----------------------------------------------------------------------------
package crt_pkg;

   // item command codes
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_PULSE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_WRITE = 2'd3
   } cmd_type;

   // bus access size codes
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;
   localparam logic [1:0] SIZE_NONE = 2'd3;

   // byte offsets within the register
   localparam logic [1:0] OFS_COUNT_LO = 2'd0;
   localparam logic [1:0] OFS_COUNT_HI = 2'd1;
   localparam logic [1:0] OFS_CTRL_LO  = 2'd2;
   localparam logic [1:0] OFS_CTRL_HI  = 2'd3;

   // prescaler select codes
   localparam logic [1:0] PSC_DIV1    = 2'd0;
   localparam logic [1:0] PSC_DIV64   = 2'd1;
   localparam logic [1:0] PSC_DIV256  = 2'd2;
   localparam logic [1:0] PSC_DIV1024 = 2'd3;

   // control bit positions
   localparam int CTRL_CASCADE_BIT = 2;
   localparam int CTRL_START_BIT   = 7;

   // widths
   localparam int COUNT_W    = 16;
   localparam int PRESCALE_W = 10;
   localparam int DIV_W      = PRESCALE_W + 1;
   localparam int DELAY_W    = 2;
   localparam int DATA_W     = 32;

   // ticks from start until prescaled counting begins
   localparam logic [DELAY_W-1:0] START_DELAY_TICKS = 2'd2;

   // one input beat
   typedef struct packed {
      cmd_type           command;
      logic [1:0]        byte_offset;
      logic [1:0]        access_size;
      logic [DATA_W-1:0] write_data;
   } item_type;

   // one result beat
   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic              overflow;
   } result_type;

   // prescaler divide ratio
   function automatic logic [DIV_W-1:0] divider(input logic [1:0] sel);
      logic [DIV_W-1:0] d;
      case (sel)
         PSC_DIV1:   d = 11'd1;
         PSC_DIV64:  d = 11'd64;
         PSC_DIV256: d = 11'd256;
         default:    d = 11'd1024;
      endcase
      return d;
   endfunction

endpackage

### hdl/crt_core.sv
// ----------------------------------------------------------------------------
// crt_core
// Timer state and the update for one beat: tick, cascade pulse, bus read
// or bus write. The result is combinational from the beat.
// ----------------------------------------------------------------------------
module crt_core
   import crt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   output result_type result
);

   logic [COUNT_W-1:0]    reload_ff, reload_in;
   logic [COUNT_W-1:0]    control_ff, control_in;
   logic [COUNT_W-1:0]    counter_ff, counter_in;
   logic [PRESCALE_W-1:0] presc_ff, presc_in;
   logic [DELAY_W-1:0]    delay_ff, delay_in;

   logic                  was_run, was_casc, new_run, new_casc;
   logic [3:0][7:0]       cur_bytes, new_bytes;
   logic [3:0][7:0]       data_bytes;
   logic [2:0]            span;
   logic [COUNT_W-1:0]    counter_inc;
   logic                  counter_wrap;
   logic [DIV_W-1:0]      presc_next;

   assign was_run      = control_ff[CTRL_START_BIT];
   assign was_casc     = control_ff[CTRL_CASCADE_BIT];
   assign counter_inc  = counter_ff + 16'd1;
   assign counter_wrap = (counter_inc == '0);
   assign presc_next   = {1'b0, presc_ff} + 11'd1;
   assign data_bytes   = item.write_data;
   assign cur_bytes    = {control_ff, reload_ff};

   // bytes covered by the access
   always_comb begin
      case (item.access_size)
         SIZE_BYTE: span = 3'd1;
         SIZE_HALF: span = 3'd2;
         SIZE_WORD: span = 3'd4;
         default:   span = 3'd0;
      endcase
   end

   // byte merge of a write into reload and control
   always_comb begin
      logic [1:0] k;
      new_bytes = cur_bytes;
      for (int p = 0; p < 4; p++) begin
         k = 2'(p) - item.byte_offset;
         if ((2'(p) >= item.byte_offset) && ({1'b0, k} < span)) begin
            new_bytes[p] = data_bytes[k];
         end
      end
   end

   assign new_run  = new_bytes[2][CTRL_START_BIT];
   assign new_casc = new_bytes[2][CTRL_CASCADE_BIT];

   // state update and result
   always_comb begin
      reload_in  = reload_ff;
      control_in = control_ff;
      counter_in = counter_ff;
      presc_in   = presc_ff;
      delay_in   = delay_ff;
      result     = '0;
      unique case (item.command)
         CMD_TICK: begin
            if (was_run && !was_casc) begin
               if (delay_ff != '0) begin
                  delay_in = delay_ff - 2'd1;
               end else if (presc_next >= divider(control_ff[1:0])) begin
                  presc_in        = '0;
                  counter_in      = counter_wrap ? reload_ff : counter_inc;
                  result.overflow = counter_wrap;
               end else begin
                  presc_in = presc_next[PRESCALE_W-1:0];
               end
            end
         end
         CMD_PULSE: begin
            if (was_run && was_casc) begin
               counter_in      = counter_wrap ? reload_ff : counter_inc;
               result.overflow = counter_wrap;
            end
         end
         CMD_READ: begin
            if (item.access_size != SIZE_NONE) begin
               case (item.byte_offset)
                  OFS_COUNT_LO: begin
                     if (item.access_size == SIZE_BYTE) begin
                        result.read_data = {24'd0, counter_ff[7:0]};
                     end else if (item.access_size == SIZE_HALF) begin
                        result.read_data = {16'd0, counter_ff};
                     end else begin
                        result.read_data = {control_ff, counter_ff};
                     end
                  end
                  OFS_COUNT_HI: result.read_data = {24'd0, counter_ff[15:8]};
                  OFS_CTRL_LO: begin
                     if (item.access_size == SIZE_BYTE) begin
                        result.read_data = {24'd0, control_ff[7:0]};
                     end else if (item.access_size == SIZE_HALF) begin
                        result.read_data = {16'd0, control_ff};
                     end
                  end
                  default: result.read_data = {24'd0, control_ff[15:8]};
               endcase
            end
         end
         default: begin
            if (item.access_size != SIZE_NONE) begin
               reload_in  = {new_bytes[1], new_bytes[0]};
               control_in = {new_bytes[3], new_bytes[2]};
               if (was_run && !was_casc && new_casc) begin
                  // counter and prescaler hold
               end else if (was_run && new_run && was_casc && !new_casc) begin
                  presc_in = '0;
                  delay_in = '0;
               end else if (!was_run && new_run) begin
                  counter_in = {new_bytes[1], new_bytes[0]};
                  presc_in   = '0;
                  delay_in   = new_casc ? '0 : START_DELAY_TICKS;
               end else if (was_run && !new_run) begin
                  delay_in = '0;
               end
            end
         end
      endcase
   end

   // timer state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff  <= '0;
         control_ff <= '0;
         counter_ff <= '0;
         presc_ff   <= '0;
         delay_ff   <= '0;
      end else if (fire) begin
         reload_ff  <= reload_in;
         control_ff <= control_in;
         counter_ff <= counter_in;
         presc_ff   <= presc_in;
         delay_ff   <= delay_in;
      end
   end

endmodule

### hdl/cascadable_reload_timer_unit.sv
// ----------------------------------------------------------------------------
// cascadable_reload_timer_unit
// 16-bit prescaled cascadable reload timer, one beat per cycle unless stalled.
// ----------------------------------------------------------------------------
// Each request beat is a clock tick, a cascade pulse, a bus read or a bus
// write of the 4-byte register (low half: counter on reads, reload on writes;
// high half: control), and gives exactly one response beat. The unit takes
// one beat every cycle while the response side does not stall; a beat's
// response shows once it has passed the input and then the result register.
// The timer state updates as the beat moves from the input register into the
// result register. Backpressure on the response side stalls both stages.
module cascadable_reload_timer_unit
   import crt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_command,
   input  logic [1:0]        req_byte_offset,
   input  logic [1:0]        req_access_size,
   input  logic [DATA_W-1:0] req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_read_data,
   output logic              rsp_overflow
);

   logic       stage_v_ff, stage_v_in;
   item_type   stage_ff;
   logic       out_v_ff, out_v_in;
   result_type out_ff;
   result_type core_result;
   logic       advance;
   logic       req_take;

   // pipeline flow
   assign advance   = stage_v_ff && (!out_v_ff || rsp_ready);
   assign req_ready = !stage_v_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign stage_v_in = req_take ? 1'b1 : (advance ? 1'b0 : stage_v_ff);
   assign out_v_in   = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_v_ff);

   // timer core
   crt_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (stage_ff),
      .result (core_result)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         stage_v_ff <= stage_v_in;
         out_v_ff   <= out_v_in;
      end
   end

   // input and result payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff.command     <= cmd_type'(req_command);
         stage_ff.byte_offset <= req_byte_offset;
         stage_ff.access_size <= req_access_size;
         stage_ff.write_data  <= req_write_data;
      end
      if (advance) begin
         out_ff <= core_result;
      end
   end

   assign rsp_valid     = out_v_ff;
   assign rsp_read_data = out_ff.read_data;
   assign rsp_overflow  = out_ff.overflow;

endmodule

### hdl/crt_checker.sv
// ----------------------------------------------------------------------------
// crt_checker
// Port-level checks of the reload timer unit, bound to the top level.
// ----------------------------------------------------------------------------
module crt_checker
   import crt_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_read_data,
   input logic              rsp_overflow
);

   // no response beat right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_overflow))
      else $error("stalled response changed");

   // overflow only comes from ticks and pulses, which read as zero
   a_ovf_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_read_data == '0)
      else $error("overflow beat carries read data");

   // an empty result register never blocks requests
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

endmodule

bind cascadable_reload_timer_unit crt_checker u_crt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_read_data (rsp_read_data),
   .rsp_overflow  (rsp_overflow)
);
